// ----- design/sliding_window_stability_detector_unit_defines.svh -----
// Assertion macros for the stability detector RTL.
// Assertions compile away when SYNTHESIS is defined; no other dependencies.
`ifndef SLIDING_WINDOW_STABILITY_DETECTOR_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_STABILITY_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SWSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SWSD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SWSD_ASSERT(lbl, clk, rst_n, prop, msg)

`define SWSD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- design/swsd_pkg.sv -----
// Shared constants, register indexes and controller/datapath structs
// for the sliding window stability detector. No dependencies.
package swsd_pkg;

	// default sizing
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int OUT_W      = 16;
	localparam int LEN_REG_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int REL_SHIFT  = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_TOL       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REL_TOL       = 2'd2;

	// register reset values
	localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;
	localparam logic [OUT_W-1:0]     QUAL_ONE  = 16'hFFFF;

	// shared divider operand select
	typedef logic [1:0] div_sel_t;
	localparam div_sel_t DIV_MEAN = 2'd0;
	localparam div_sel_t DIV_VAR  = 2'd1;
	localparam div_sel_t DIV_QUAL = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic     load;
		logic     clear;
		logic     push;
		logic     scan_start;
		logic     rd;
		logic     pass2;
		logic     div_start;
		div_sel_t div_sel;
		logic     mean_ld;
		logic     sqrt_start;
		logic     out_ld;
	} swsd_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic mode;
		logic idx_last;
		logic pipe_busy;
		logic div_busy;
		logic sqrt_busy;
		logic qual_div;
	} swsd_status_t;

endpackage

// ----- design/swsd_ifs.sv -----
// Valid/ready channel interfaces: sample feed, result and register write.
// Depends on swsd_pkg for the default sizing and the fixed field widths.
interface swsd_in_if #(
	parameter int SB = swsd_pkg::SAMPLE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic signed [SB-1:0] sample;

	modport source (output valid, mode, sample, input ready);
	modport sink   (input valid, mode, sample, output ready);
endinterface

interface swsd_out_if #(
	parameter int SB = swsd_pkg::SAMPLE_BITS_DEF,
	parameter int CW = 7
);
	logic                            valid;
	logic                            ready;
	logic signed [SB-1:0]            mean;
	logic signed [SB-1:0]            minimum;
	logic signed [SB-1:0]            maximum;
	logic [swsd_pkg::OUT_W-1:0]      std_dev;
	logic [swsd_pkg::OUT_W-1:0]      span_size;
	logic [swsd_pkg::OUT_W-1:0]      span_limit;
	logic [CW-1:0]                   fill_level;
	logic                            stable;
	logic [swsd_pkg::OUT_W-1:0]      quality;

	modport source (output valid, mean, minimum, maximum, std_dev, span_size,
		span_limit, fill_level, stable, quality, input ready);
	modport sink   (input valid, mean, minimum, maximum, std_dev, span_size,
		span_limit, fill_level, stable, quality, output ready);
endinterface

interface swsd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swsd_pkg::CFG_IDX_W-1:0]  index;
	logic [swsd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/sliding_window_stability_detector_unit.sv -----
// Top level of the sliding window stability detector: controller plus
// datapath. Uses swsd_pkg, swsd_ifs, swsd_ctrl and swsd_datapath.
//
//  channel  dir  transaction payload
//  feed     in   mode, sample
//  result   out  mean, minimum, maximum, std_dev, span_size,
//                span_limit, fill_level, stable, quality
//  cfg      in   index, data (always ready)
//
// A push runs two scans through the single read port of the window
// memory, up to three runs of the shared bit-serial divider (the third
// is skipped when the quality needs no division) and a 16-step root.
// Reset clears the window through per-entry valid bits at once. A new
// item is taken while the previous result waits; a stalled result holds
// the block in its last state until it is taken.
module sliding_window_stability_detector_unit #(
	parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	swsd_in_if.sink    feed,
	swsd_out_if.source result,
	swsd_cfg_if.sink   cfg
);
	import swsd_pkg::*;

	localparam int CW = $clog2(MAX_WINDOW + 1);

	swsd_cmd_t    cmd;
	swsd_status_t st;

	assign cfg.ready = 1'b1;

	swsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feed.valid),
		.in_ready  (feed.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.st        (st)
	);

	swsd_datapath #(
		.MW(MAX_WINDOW),
		.SB(SAMPLE_BITS),
		.CW(CW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_mode        (feed.mode),
		.in_sample      (feed.sample),
		.cfg_we         (cfg.valid),
		.cfg_idx        (cfg.index),
		.cfg_data       (cfg.data),
		.res_mean       (result.mean),
		.res_minimum    (result.minimum),
		.res_maximum    (result.maximum),
		.res_std_dev    (result.std_dev),
		.res_span_size  (result.span_size),
		.res_span_limit (result.span_limit),
		.res_fill_level (result.fill_level),
		.res_stable     (result.stable),
		.res_quality    (result.quality)
	);
endmodule

// ----- design/swsd_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
// No package dependencies.
module swsd_divider #(
	parameter int DVW = 39,
	parameter int DSW = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	output logic           busy,
	output logic [DVW-1:0] quotient,
	output logic [DSW-1:0] remainder
);
	localparam int CNW = $clog2(DVW + 1);

	logic           busy_q;
	logic [CNW-1:0] cnt_q;
	logic [DVW-1:0] quo_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dvs_q;
	logic [DSW:0]   shifted;
	logic           ge;
	logic [DSW:0]   diff;

	// trial subtract of the next partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[DVW-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(DVW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient and remainder shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVW-2:0], ge};
			rem_q <= ge ? DSW'(diff) : DSW'(shifted);
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ----- design/swsd_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
// No package dependencies.
module swsd_isqrt #(
	parameter int RW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW-1:0]   radicand,
	output logic            busy,
	output logic [RW/2-1:0] root
);
	localparam int RTW  = RW / 2;
	localparam int REMW = RTW + 3;
	localparam int CNW  = $clog2(RTW + 1);

	logic            busy_q;
	logic [CNW-1:0]  cnt_q;
	logic [RW-1:0]   rad_q;
	logic [REMW-1:0] rem_q;
	logic [RTW-1:0]  root_q;
	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] trial;
	logic            ge;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		rem_sh = {rem_q[REMW-3:0], rad_q[RW-1:RW-2]};
		trial  = REMW'({root_q, 2'b01});
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(RTW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RTW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// ----- design/swsd_datapath.sv -----
// Datapath: configuration registers, sample window memory, two scan
// passes, shared divider and square root, result register. Uses swsd_pkg.
module swsd_datapath #(
	parameter int MW = swsd_pkg::MAX_WINDOW_DEF,
	parameter int SB = swsd_pkg::SAMPLE_BITS_DEF,
	parameter int CW = $clog2(MW + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swsd_pkg::swsd_cmd_t               cmd,
	output swsd_pkg::swsd_status_t            st,
	input  logic                              in_mode,
	input  logic signed [SB-1:0]              in_sample,
	input  logic                              cfg_we,
	input  logic [swsd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swsd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic signed [SB-1:0]              res_mean,
	output logic signed [SB-1:0]              res_minimum,
	output logic signed [SB-1:0]              res_maximum,
	output logic [swsd_pkg::OUT_W-1:0]        res_std_dev,
	output logic [swsd_pkg::OUT_W-1:0]        res_span_size,
	output logic [swsd_pkg::OUT_W-1:0]        res_span_limit,
	output logic [CW-1:0]                     res_fill_level,
	output logic                              res_stable,
	output logic [swsd_pkg::OUT_W-1:0]        res_quality
);
	import swsd_pkg::*;

	localparam int AW   = $clog2(MW);
	localparam int SUMW = SB + CW;
	localparam int SQW  = 2 * SB + CW;
	localparam int DVW  = (SQW > 32) ? SQW : 32;
	localparam int DSW  = OUT_W;
	localparam int RW   = 2 * SB;
	localparam int PW   = OUT_W + SB;
	localparam int SPW  = SB + 1;
	localparam int CMPW = SPW + OUT_W;

	// configuration
	logic [LEN_REG_W-1:0] wlen_q;
	logic [OUT_W-1:0]     abs_tol_q;
	logic [OUT_W-1:0]     rel_tol_q;

	// item and window state
	logic                 mode_q;
	logic signed [SB-1:0] sample_q;
	logic [CW-1:0]        len_q;
	logic [AW-1:0]        wp_q;
	logic [CW-1:0]        fill_q;
	logic [MW-1:0]        vld_q;
	logic signed [SB-1:0] win_mem_q [MW];

	// push arithmetic
	logic [CW-1:0] len_c;
	logic [AW-1:0] wp_adj;
	logic [CW-1:0] fill_adj;
	logic [CW-1:0] wp_inc;

	// scan pipeline
	logic [CW-1:0]        idx_q;
	logic                 rd_s1;
	logic                 pass2_s1;
	logic                 first_s1;
	logic                 rd_vld_s1;
	logic signed [SB-1:0] rd_data_s1;
	logic signed [SB-1:0] val;
	logic signed [SPW-1:0] diff;
	logic                 v_s2;
	logic [SB-1:0]        absd_s2;
	logic                 v_s3;
	logic [2*SB-1:0]      sqr_s3;

	// accumulators
	logic signed [SUMW-1:0] sum_q;
	logic signed [SB-1:0]   mn_q;
	logic signed [SB-1:0]   mx_q;
	logic [SQW-1:0]         sq_q;
	logic signed [SB-1:0]   mean_q;
	logic [SUMW-1:0]        sum_mag;
	logic                   sum_neg;
	logic [SB-1:0]          mean_mag;
	logic [SB-1:0]          absmean;
	logic [PW-1:0]          rel_prod_q;
	logic [PW-1:0]          rel_full;
	logic [OUT_W-1:0]       rel_sat;
	logic [OUT_W-1:0]       allowed;
	logic [SPW-1:0]         span_full;
	logic [CMPW-1:0]        span_ext;
	logic [CMPW-1:0]        allowed_ext;
	logic [OUT_W-1:0]       headroom;
	logic                   full;
	logic                   span_le;
	logic                   span_lt;
	logic [OUT_W-1:0]       quality_c;

	// shared units
	logic [DVW-1:0] div_dividend;
	logic [DSW-1:0] div_divisor;
	logic           div_busy;
	logic [DVW-1:0] div_quot;
	logic [DSW-1:0] div_rem;
	logic           sqrt_busy;
	logic [SB-1:0]  sqrt_root;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= LEN_RESET;
			abs_tol_q <= '0;
			rel_tol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WINDOW_LENGTH: wlen_q    <= cfg_data[LEN_REG_W-1:0];
				REG_ABS_TOL:       abs_tol_q <= cfg_data;
				REG_REL_TOL:       rel_tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated length and ring pointer update
	always_comb begin
		if (wlen_q < LEN_REG_W'(2)) begin
			len_c = CW'(2);
		end else if (32'(wlen_q) > MW) begin
			len_c = CW'(MW);
		end else begin
			len_c = CW'(wlen_q);
		end
		wp_adj   = (CW'(wp_q) >= len_c) ? '0 : wp_q;
		fill_adj = (fill_q > len_c) ? len_c : fill_q;
		wp_inc   = CW'(wp_adj) + 1'b1;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_mode;
			sample_q <= in_sample;
		end
		if (cmd.push) begin
			len_q <= len_c;
		end
	end

	// window pointers and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			vld_q  <= '0;
		end else if (cmd.clear) begin
			wp_q   <= '0;
			fill_q <= '0;
			vld_q  <= '0;
		end else if (cmd.push) begin
			wp_q          <= (wp_inc >= len_c) ? '0 : AW'(wp_inc);
			fill_q        <= (fill_adj < len_c) ? fill_adj + 1'b1 : fill_adj;
			vld_q[wp_adj] <= 1'b1;
		end
	end

	// sample memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_mem_q[wp_adj] <= sample_q;
		end
		if (cmd.rd) begin
			rd_data_s1 <= win_mem_q[idx_q[AW-1:0]];
		end
	end

	// scan index and pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_s1     <= 1'b0;
			pass2_s1  <= 1'b0;
			first_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.rd) begin
				idx_q <= idx_q + 1'b1;
			end
			rd_s1     <= cmd.rd;
			pass2_s1  <= cmd.pass2;
			first_s1  <= (idx_q == '0);
			rd_vld_s1 <= vld_q[idx_q[AW-1:0]];
			v_s2      <= rd_s1 && pass2_s1;
			v_s3      <= v_s2;
		end
	end

	// never-written entries read as zero
	always_comb begin
		val  = rd_vld_s1 ? rd_data_s1 : '0;
		diff = SPW'(val) - SPW'(mean_q);
	end

	// pass 1: sum, min, max; pass 2: squared deviation
	always_ff @(posedge clk) begin
		if (rd_s1 && !pass2_s1) begin
			if (first_s1) begin
				sum_q <= SUMW'(val);
				mn_q  <= val;
				mx_q  <= val;
			end else begin
				sum_q <= sum_q + SUMW'(val);
				if (val < mn_q) mn_q <= val;
				if (val > mx_q) mx_q <= val;
			end
		end
		absd_s2 <= diff[SPW-1] ? SB'(-diff) : SB'(diff);
		sqr_s3  <= absd_s2 * absd_s2;
		if (cmd.scan_start) begin
			sq_q <= '0;
		end else if (v_s3) begin
			sq_q <= sq_q + SQW'(sqr_s3);
		end
		if (cmd.mean_ld) begin
			mean_q <= sum_neg ? -mean_mag : SB'(div_quot);
		end
		rel_prod_q <= PW'(rel_tol_q) * PW'(absmean);
	end

	// floored mean from magnitude quotient
	always_comb begin
		sum_neg  = sum_q[SUMW-1];
		sum_mag  = sum_neg ? SUMW'(-sum_q) : SUMW'(sum_q);
		mean_mag = SB'(div_quot) + SB'(div_rem != '0);
		absmean  = mean_q[SB-1] ? SB'(-mean_q) : SB'(mean_q);
	end

	// allowance, span, stability
	always_comb begin
		rel_full    = rel_prod_q >> REL_SHIFT;
		rel_sat     = (rel_full > PW'(QUAL_ONE)) ? QUAL_ONE : OUT_W'(rel_full);
		allowed     = (rel_sat > abs_tol_q) ? rel_sat : abs_tol_q;
		span_full   = SPW'(mx_q) - SPW'(mn_q);
		span_ext    = CMPW'(span_full);
		allowed_ext = CMPW'(allowed);
		headroom    = OUT_W'(allowed_ext - span_ext);
		full        = (fill_q == len_q);
		span_le     = span_ext <= allowed_ext;
		span_lt     = span_ext < allowed_ext;
		if (!full || (allowed != '0 && span_lt)) begin
			quality_c = OUT_W'(div_quot);
		end else if (allowed == '0 && span_full == '0) begin
			quality_c = QUAL_ONE;
		end else begin
			quality_c = '0;
		end
	end

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DIV_MEAN: begin
				div_dividend = DVW'(sum_mag);
				div_divisor  = DSW'(fill_q);
			end
			DIV_VAR: begin
				div_dividend = DVW'(sq_q);
				div_divisor  = DSW'(fill_q);
			end
			DIV_QUAL: begin
				if (!full) begin
					div_dividend = (DVW'(fill_q) << OUT_W) - DVW'(fill_q);
					div_divisor  = DSW'(len_q);
				end else begin
					div_dividend = (DVW'(headroom) << OUT_W) - DVW'(headroom);
					div_divisor  = DSW'(allowed);
				end
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	swsd_divider #(
		.DVW(DVW),
		.DSW(DSW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	swsd_isqrt #(
		.RW(RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (RW'(div_quot)),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	// result register; a clear answers all zeros
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			if (mode_q) begin
				res_mean       <= '0;
				res_minimum    <= '0;
				res_maximum    <= '0;
				res_std_dev    <= '0;
				res_span_size  <= '0;
				res_span_limit <= '0;
				res_fill_level <= '0;
				res_stable     <= 1'b0;
				res_quality    <= '0;
			end else begin
				res_mean       <= mean_q;
				res_minimum    <= mn_q;
				res_maximum    <= mx_q;
				res_std_dev    <= OUT_W'(sqrt_root);
				res_span_size  <= OUT_W'(span_full);
				res_span_limit <= allowed;
				res_fill_level <= fill_q;
				res_stable     <= full && span_le;
				res_quality    <= quality_c;
			end
		end
	end

	// status to controller
	always_comb begin
		st.mode      = mode_q;
		st.idx_last  = (idx_q == fill_q - 1'b1);
		st.pipe_busy = rd_s1 || v_s2 || v_s3;
		st.div_busy  = div_busy;
		st.sqrt_busy = sqrt_busy;
		st.qual_div  = !full || (allowed != '0 && span_lt);
	end
endmodule

// ----- design/swsd_ctrl.sv -----
// Controller state machine: sequences push or clear, two scans, divisions,
// square root and result handoff. Uses swsd_pkg and the assertion macros.
`include "sliding_window_stability_detector_unit_defines.svh"

module swsd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output swsd_pkg::swsd_cmd_t    cmd,
	input  swsd_pkg::swsd_status_t st
);
	import swsd_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PUSH   = 4'd1;
	localparam logic [3:0] S_P1     = 4'd2;
	localparam logic [3:0] S_P1W    = 4'd3;
	localparam logic [3:0] S_MEAN   = 4'd4;
	localparam logic [3:0] S_MEAN_W = 4'd5;
	localparam logic [3:0] S_P2     = 4'd6;
	localparam logic [3:0] S_P2W    = 4'd7;
	localparam logic [3:0] S_VAR    = 4'd8;
	localparam logic [3:0] S_VAR_W  = 4'd9;
	localparam logic [3:0] S_SQRT_W = 4'd10;
	localparam logic [3:0] S_QUAL   = 4'd11;
	localparam logic [3:0] S_QUAL_W = 4'd12;
	localparam logic [3:0] S_OUT    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PUSH;
				end
			end
			S_PUSH: begin
				if (st.mode) begin
					cmd.clear = 1'b1;
					state_d   = S_OUT;
				end else begin
					cmd.push       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_P1;
				end
			end
			S_P1: begin
				cmd.rd = 1'b1;
				if (st.idx_last) state_d = S_P1W;
			end
			S_P1W: begin
				if (!st.pipe_busy) state_d = S_MEAN;
			end
			S_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MEAN;
				state_d       = S_MEAN_W;
			end
			S_MEAN_W: begin
				cmd.div_sel = DIV_MEAN;
				if (!st.div_busy) begin
					cmd.mean_ld    = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_P2;
				end
			end
			S_P2: begin
				cmd.rd    = 1'b1;
				cmd.pass2 = 1'b1;
				if (st.idx_last) state_d = S_P2W;
			end
			S_P2W: begin
				if (!st.pipe_busy) state_d = S_VAR;
			end
			S_VAR: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_VAR;
				state_d       = S_VAR_W;
			end
			S_VAR_W: begin
				cmd.div_sel = DIV_VAR;
				if (!st.div_busy) begin
					cmd.sqrt_start = 1'b1;
					state_d        = S_SQRT_W;
				end
			end
			S_SQRT_W: begin
				if (!st.sqrt_busy) state_d = S_QUAL;
			end
			S_QUAL: begin
				cmd.div_sel = DIV_QUAL;
				if (st.qual_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_QUAL_W;
				end else begin
					state_d = S_OUT;
				end
			end
			S_QUAL_W: begin
				cmd.div_sel = DIV_QUAL;
				if (!st.div_busy) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_ld || (out_valid_q && !out_ready);
		end
	end

	`SWSD_ASSERT(a_out_no_overwrite, clk, arst_n, cmd.out_ld |-> (!out_valid_q || out_ready), "result register overwritten")
	`SWSD_ASSERT_NEVER(a_div_restart, clk, arst_n, cmd.div_start && st.div_busy, "divider started while busy")
	`SWSD_ASSERT_NEVER(a_sqrt_overlap, clk, arst_n, cmd.sqrt_start && (st.div_busy || st.sqrt_busy), "square root started early")
	`SWSD_ASSERT(a_one_item, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for sliding_window_stability_detector_unit.
// Uses swsd_pkg and the channel interfaces in swsd_ifs; holds its own predictor
// of the window statistics and compares every result transaction against it.
`timescale 1ns / 1ps

module tb;
	import swsd_pkg::*;

	localparam int WIN_MAX     = 64;
	localparam int IDLE_LIMIT  = 5000;
	localparam int DRAIN_WAIT  = 300;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 180;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic MODE_PUSH  = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef struct packed {
		logic [15:0] mean;
		logic [15:0] minimum;
		logic [15:0] maximum;
		logic [15:0] std_dev;
		logic [15:0] span_size;
		logic [15:0] span_limit;
		logic [6:0]  fill_level;
		logic        stable;
		logic [15:0] quality;
	} stats_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] sample;
		logic        typed;
		stats_t      stats;
	} vec_t;

	typedef struct packed {
		logic [15:0] len;
		logic [15:0] abs_tol;
		logic [15:0] rel_tol;
		logic [15:0] noise;
	} setting_t;

	logic clk;
	logic arst_n;

	swsd_in_if  feed ();
	swsd_out_if result ();
	swsd_cfg_if cfg ();

	sliding_window_stability_detector_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.result (result),
		.cfg    (cfg)
	);

	// model state
	longint      win [WIN_MAX];
	int unsigned wr_pos;
	int unsigned fill;
	logic [6:0]  len_reg;
	logic [15:0] abs_reg;
	logic [15:0] rel_reg;

	stats_t expected_q [$];
	int     fails;
	int     idle_cycles;
	int     stall_hold;
	bit     steady_sink;
	bit     steady_source;

	always #5 clk = ~clk;

	function automatic longint floor_root(longint v);
		longint r;
		longint t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// window statistics for one accepted feed transaction
	function automatic stats_t window_stats(logic mode, logic [15:0] smp);
		stats_t      r;
		int unsigned len;
		longint      sum, mn, mx, mean, sq, d, span, absmean, rel, allowed, qual;
		r = '0;
		len = len_reg;
		if (len < 2) len = 2;
		if (len > WIN_MAX) len = WIN_MAX;
		if (mode == MODE_CLEAR) begin
			foreach (win[i]) win[i] = 0;
			wr_pos = 0;
			fill = 0;
			return r;
		end
		// length may have been lowered since the last push
		if (wr_pos >= len) wr_pos = 0;
		if (fill > len) fill = len;
		win[wr_pos] = longint'($signed(smp));
		wr_pos++;
		if (wr_pos >= len) wr_pos = 0;
		if (fill < len) fill++;
		sum = 0;
		mn = win[0];
		mx = win[0];
		for (int i = 0; i < fill; i++) begin
			sum += win[i];
			if (win[i] < mn) mn = win[i];
			if (win[i] > mx) mx = win[i];
		end
		if (sum >= 0) mean = sum / fill;
		else mean = -((-sum + fill - 1) / fill);
		sq = 0;
		for (int i = 0; i < fill; i++) begin
			d = win[i] - mean;
			sq += d * d;
		end
		span = mx - mn;
		absmean = (mean < 0) ? -mean : mean;
		rel = (longint'(rel_reg) * absmean) >>> REL_SHIFT;
		if (rel > 65535) rel = 65535;
		allowed = (rel > abs_reg) ? rel : longint'(abs_reg);
		if (fill < len) qual = (longint'(fill) * 65535) / len;
		else if (allowed > 0) qual = (span >= allowed) ? 0 : ((allowed - span) * 65535) / allowed;
		else qual = (span == 0) ? 65535 : 0;
		r.mean       = mean[15:0];
		r.minimum    = mn[15:0];
		r.maximum    = mx[15:0];
		r.std_dev    = 16'(floor_root(sq / fill));
		r.span_size  = span[15:0];
		r.span_limit = allowed[15:0];
		r.fill_level = fill[6:0];
		r.stable     = (fill == len) && (span <= allowed);
		r.quality    = qual[15:0];
		return r;
	endfunction

	task automatic send(logic mode, logic [15:0] smp, bit typed, stats_t typed_stats);
		stats_t p;
		int     gap;
		int     r;
		feed.valid  <= 1'b1;
		feed.mode   <= mode;
		feed.sample <= smp;
		@(posedge clk);
		while (!feed.ready) @(posedge clk);
		p = window_stats(mode, smp);
		expected_q.push_back(typed ? typed_stats : p);
		r = $urandom_range(99);
		if (steady_source || r < 60) gap = 0;
		else if (r < 92) gap = $urandom_range(3, 1);
		else gap = $urandom_range(60, 10);
		if (gap > 0) begin
			feed.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_WINDOW_LENGTH: len_reg = val[6:0];
			REG_ABS_TOL:       abs_reg = val;
			REG_REL_TOL:       rel_reg = val;
			default: ;
		endcase
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	// result sink stalls
	always @(posedge clk) begin
		int r;
		if (stall_hold > 0) begin
			stall_hold--;
			result.ready <= 1'b0;
		end else begin
			r = $urandom_range(99);
			if (steady_sink || r < 70) begin
				result.ready <= 1'b1;
			end else if (r < 95) begin
				result.ready <= 1'b0;
				stall_hold = $urandom_range(2);
			end else begin
				result.ready <= 1'b0;
				stall_hold = $urandom_range(80, 20);
			end
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		stats_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected");
				fails++;
			end else begin
				e = expected_q.pop_front();
				check_field("mean", e.mean, result.mean);
				check_field("minimum", e.minimum, result.minimum);
				check_field("maximum", e.maximum, result.maximum);
				check_field("std_dev", e.std_dev, result.std_dev);
				check_field("span_size", e.span_size, result.span_size);
				check_field("span_limit", e.span_limit, result.span_limit);
				check_field("fill_level", 16'(e.fill_level), 16'(result.fill_level));
				check_field("stable", 16'(e.stable), 16'(result.stable));
				check_field("quality", e.quality, result.quality);
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((feed.valid && feed.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		vec_t     dir [12];
		setting_t phases [N_PHASES];
		stats_t   zero;
		stats_t   first_min;
		stats_t   first_max;
		int       r;
		int       base;
		logic [15:0] smp;

		clk = 1'b0;
		arst_n = 1'b0;
		feed.valid = 1'b0;
		feed.mode = MODE_PUSH;
		feed.sample = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_WINDOW_LENGTH;
		cfg.data = '0;
		result.ready = 1'b0;
		fails = 0;
		idle_cycles = 0;
		stall_hold = 0;
		steady_sink = 1'b0;
		steady_source = 1'b0;
		foreach (win[i]) win[i] = 0;
		wr_pos = 0;
		fill = 0;
		len_reg = LEN_RESET;
		abs_reg = '0;
		rel_reg = '0;

		// first push after a clear at reset settings: one sample of 64
		zero = '0;
		first_min = '{16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 7'd1, 1'b0, 16'd1023};
		first_max = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 7'd1, 1'b0, 16'd1023};
		dir = '{
			'{MODE_CLEAR, 16'h1234, 1'b1, zero},
			'{MODE_PUSH,  16'h8000, 1'b1, first_min},
			'{MODE_PUSH,  16'h7FFF, 1'b0, zero},
			'{MODE_PUSH,  16'h0000, 1'b0, zero},
			'{MODE_PUSH,  16'hFFFF, 1'b0, zero},
			'{MODE_PUSH,  16'h0001, 1'b0, zero},
			'{MODE_PUSH,  16'h5555, 1'b0, zero},
			'{MODE_PUSH,  16'hAAAA, 1'b0, zero},
			'{MODE_CLEAR, 16'hFFFF, 1'b1, zero},
			'{MODE_PUSH,  16'h7FFF, 1'b1, first_max},
			'{MODE_PUSH,  16'h8000, 1'b0, zero},
			'{MODE_PUSH,  16'hFFFF, 1'b0, zero}
		};

		// length, abs tol, rel tol, noise; out-of-range lengths saturate,
		// and the step from 64 to 3 lowers the length over a full window
		phases = '{
			'{16'd64,   16'd0,     16'd0,     16'd8},
			'{16'd2,    16'hFFFF,  16'hFFFF,  16'd300},
			'{16'd0,    16'd0,     16'hFFFF,  16'd1},
			'{16'd1,    16'd5,     16'd40,    16'd4},
			'{16'hFFFF, 16'd20,    16'd4096,  16'd8},
			'{16'd64,   16'd100,   16'd200,   16'd40},
			'{16'd3,    16'd0,     16'd0,     16'd0},
			'{16'd16,   16'd2000,  16'd1000,  16'd900}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		foreach (dir[i])
			send(dir[i].mode, dir[i].sample, dir[i].typed, dir[i].stats);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// drop the feed first so the last item is not taken twice
			feed.valid <= 1'b0;
			wait_drain();
			@(posedge clk);
			write_reg(REG_WINDOW_LENGTH, phases[ph].len);
			write_reg(REG_ABS_TOL, phases[ph].abs_tol);
			write_reg(REG_REL_TOL, phases[ph].rel_tol);
			if (ph == 1)
				write_reg(REG_UNUSED, 16'hFFFF);
			steady_sink = (ph == 2);
			steady_source = (ph == 2) || (ph == 5);
			base = $urandom_range(65535);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off the feed until every result is in
				if (ph == 4 && n == 90) begin
					feed.valid <= 1'b0;
					wait_drain();
				end
				r = $urandom_range(99);
				if (r < 3) begin
					smp = 16'($urandom);
					send(MODE_CLEAR, smp, 1'b0, zero);
				end else if (r < 23) begin
					smp = 16'($urandom);
					send(MODE_PUSH, smp, 1'b0, zero);
				end else begin
					smp = 16'(base + $urandom_range(2 * phases[ph].noise) - phases[ph].noise);
					send(MODE_PUSH, smp, 1'b0, zero);
				end
			end
		end

		feed.valid <= 1'b0;
		wait_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
